// ===== rtl/dirty_rect_coalescer_core_assert.svh =====
// Assertion macros shared by the dirty rectangle coalescer RTL.
// Uses the clock and reset ports of the module that includes it.
`ifndef DIRTY_RECT_COALESCER_CORE_ASSERT_SVH
`define DIRTY_RECT_COALESCER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define DRC_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("dirty rect coalescer: assertion failed");
`define DRC_NEVER(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error("dirty rect coalescer: forbidden condition");
`else
`define DRC_ASSERT(lbl, prop)
`define DRC_NEVER(lbl, cond)
`endif
`endif

// ===== rtl/drc_pkg.sv =====
// Package for the dirty rectangle coalescer: sizes, operation codes,
// rectangle and span types. No dependencies.
package drc_pkg;

   localparam int STACK_DEPTH = 32;
   localparam int COORD_BITS  = 12;

   localparam int CNT_W      = $clog2(STACK_DEPTH + 1);
   localparam int IDX_W      = $clog2(STACK_DEPTH);
   localparam int OP_W       = 2;
   localparam int RECT_W     = 4 * COORD_BITS;
   localparam int REQ_DATA_W = ((OP_W + RECT_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((RECT_W + 7) / 8) * 8;

   localparam logic [OP_W-1:0] OP_ADD_MERGE = 2'd0;
   localparam logic [OP_W-1:0] OP_ADD_PLAIN = 2'd1;
   localparam logic [OP_W-1:0] OP_FLUSH     = 2'd2;

   // left in the lowest bits, matching the stream packing
   typedef struct packed {
      logic [COORD_BITS-1:0] height;
      logic [COORD_BITS-1:0] width;
      logic [COORD_BITS-1:0] top;
      logic [COORD_BITS-1:0] left;
   } rect_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] start;
      logic [COORD_BITS-1:0] len;
   } span_type;

   typedef struct packed {
      logic                  touch;
      logic [COORD_BITS-1:0] start;
      logic [COORD_BITS-1:0] len;
   } span_result_type;

endpackage

// ===== rtl/drc_span_unit.sv =====
// Shared span unit: touch/overlap test and saturated union of two 1-D spans.
// Depends on drc_pkg.
module drc_span_unit
   import drc_pkg::*;
(
   input  span_type        span_a,
   input  span_type        span_b,
   output span_result_type result
);

   localparam logic [COORD_BITS:0] COORD_MAX = {1'b0, {COORD_BITS{1'b1}}};

   logic [COORD_BITS:0] a_start;
   logic [COORD_BITS:0] b_start;
   logic [COORD_BITS:0] a_end;
   logic [COORD_BITS:0] b_end;
   logic [COORD_BITS:0] u_start;
   logic [COORD_BITS:0] u_end;
   logic [COORD_BITS:0] u_len;

   assign a_start = {1'b0, span_a.start};
   assign b_start = {1'b0, span_b.start};
   assign a_end   = a_start + {1'b0, span_a.len};
   assign b_end   = b_start + {1'b0, span_b.len};

   assign u_start = (a_start < b_start) ? a_start : b_start;
   assign u_end   = (a_end > b_end) ? a_end : b_end;
   assign u_len   = u_end - u_start;

   assign result.touch = (a_end >= b_start) && (b_end >= a_start);
   assign result.start = u_start[COORD_BITS-1:0];
   assign result.len   = (u_len > COORD_MAX) ? COORD_MAX[COORD_BITS-1:0]
                                             : u_len[COORD_BITS-1:0];

endmodule

// ===== rtl/dirty_rect_coalescer_core.sv =====
// Dirty rectangle coalescer, top level; one shared span unit under a small sequencer.
// Add: decode, then push; a full stack first emits a whole-screen result and is cleared;
//   each merge step reads the entry below and tests vertical, then horizontal; waits on rsp_tready stall this.
// Flush: nothing if empty, one whole-screen result if full, else each entry is read, then emitted (one read port).
// Throughput: one item at a time; req_tready is high only while idle.
// Reset: sync, active high; clears the count, not the stack RAM; drops a pending result.
`include "dirty_rect_coalescer_core_assert.svh"

module dirty_rect_coalescer_core
   import drc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // bits low to high: operation, rect_left, rect_top, rect_width, rect_height, zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // result stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // bits low to high: out_left, out_top, out_width, out_height
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // bits low to high: whole_screen
   output logic [0:0]            rsp_tuser,
   output logic                  rsp_tlast
);

   // Sequencer states, one-hot.
   typedef enum logic [9:0] {
      S_IDLE        = 10'b00_0000_0001,
      S_DECODE      = 10'b00_0000_0010,
      S_WHOLE_ADD   = 10'b00_0000_0100,
      S_WHOLE_FLUSH = 10'b00_0000_1000,
      S_PUSH        = 10'b00_0001_0000,
      S_MERGE_RD    = 10'b00_0010_0000,
      S_MERGE_V     = 10'b00_0100_0000,
      S_MERGE_H     = 10'b00_1000_0000,
      S_DRAIN_RD    = 10'b01_0000_0000,
      S_DRAIN_OUT   = 10'b10_0000_0000
   } state_type;

   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
   localparam logic [CNT_W-1:0] CNT_TWO  = CNT_W'(2);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] drain_idx_ff, drain_idx_in;
   logic [OP_W-1:0]  op_ff, op_in;
   rect_type         item_ff, item_in;
   rect_type         top_ff, top_in;

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   rect_type         rsp_rect_ff, rsp_rect_in;
   logic             rsp_whole_ff, rsp_whole_in;
   logic             rsp_last_ff, rsp_last_in;

   // stack memory
   rect_type         stack_mem [STACK_DEPTH];
   rect_type         rd_data_ff;
   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;
   rect_type         mem_wdata;
   logic             mem_re;
   logic [IDX_W-1:0] mem_raddr;

   // shared span unit
   span_type         span_a;
   span_type         span_b;
   span_result_type  span_res;

   logic             req_xfer;
   logic             out_free;
   logic [CNT_W-1:0] count_m1;
   logic [CNT_W-1:0] count_m2;
   logic             same_cols;
   logic             same_rows;
   logic             drain_last;
   logic             in_merge;
   rect_type         merged;

   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   // the output slot can take a new result this cycle
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign count_m1   = count_ff - CNT_ONE;
   assign count_m2   = count_ff - CNT_TWO;
   assign drain_last = ((CNT_W'(drain_idx_ff) + CNT_ONE) == count_ff);
   assign in_merge   = (state_ff == S_MERGE_RD) || (state_ff == S_MERGE_V) ||
                       (state_ff == S_MERGE_H);

   // a is the entry below the top (from RAM), b the top (in a register)
   assign same_cols = (rd_data_ff.left == top_ff.left) && (rd_data_ff.width == top_ff.width);
   assign same_rows = (rd_data_ff.top == top_ff.top) && (rd_data_ff.height == top_ff.height);

   // Steer the shared unit: vertical axis in S_MERGE_V, horizontal otherwise.
   always_comb begin
      if (state_ff == S_MERGE_V) begin
         span_a = '{start: rd_data_ff.top, len: rd_data_ff.height};
         span_b = '{start: top_ff.top,     len: top_ff.height};
      end else begin
         span_a = '{start: rd_data_ff.left, len: rd_data_ff.width};
         span_b = '{start: top_ff.left,     len: top_ff.width};
      end
   end

   drc_span_unit u_span (
      .span_a (span_a),
      .span_b (span_b),
      .result (span_res)
   );

   always_comb begin
      merged = rd_data_ff;
      if (state_ff == S_MERGE_V) begin
         merged.top    = span_res.start;
         merged.height = span_res.len;
      end else begin
         merged.left   = span_res.start;
         merged.width  = span_res.len;
      end
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      drain_idx_in = drain_idx_ff;
      op_in        = op_ff;
      item_in      = item_ff;
      top_in       = top_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_rect_in  = rsp_rect_ff;
      rsp_whole_in = rsp_whole_ff;
      rsp_last_in  = rsp_last_ff;
      mem_we       = 1'b0;
      mem_waddr    = count_ff[IDX_W-1:0];
      mem_wdata    = item_ff;
      mem_re       = 1'b0;
      mem_raddr    = drain_idx_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               op_in    = req_tdata[OP_W-1:0];
               item_in  = rect_type'(req_tdata[OP_W +: RECT_W]);
               state_in = S_DECODE;
            end
         end

         S_DECODE: begin
            case (op_ff)
               OP_ADD_MERGE, OP_ADD_PLAIN: begin
                  state_in = (count_ff >= CNT_FULL) ? S_WHOLE_ADD : S_PUSH;
               end
               OP_FLUSH: begin
                  drain_idx_in = '0;
                  if (count_ff == '0) begin
                     state_in = S_IDLE;
                  end else if (count_ff >= CNT_FULL) begin
                     state_in = S_WHOLE_FLUSH;
                  end else begin
                     state_in = S_DRAIN_RD;
                  end
               end
               default: begin
                  // drop the reserved operation
                  state_in = S_IDLE;
               end
            endcase
         end

         S_WHOLE_ADD, S_WHOLE_FLUSH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_rect_in  = '0;
               rsp_whole_in = 1'b1;
               rsp_last_in  = 1'b1;
               count_in     = '0;
               state_in     = (state_ff == S_WHOLE_ADD) ? S_PUSH : S_IDLE;
            end
         end

         S_PUSH: begin
            mem_we    = 1'b1;
            mem_waddr = count_ff[IDX_W-1:0];
            mem_wdata = item_ff;
            top_in    = item_ff;
            count_in  = count_ff + CNT_ONE;
            if ((op_ff == OP_ADD_MERGE) && (count_ff >= CNT_ONE)) begin
               state_in = S_MERGE_RD;
            end else begin
               state_in = S_IDLE;
            end
         end

         S_MERGE_RD: begin
            mem_re    = 1'b1;
            mem_raddr = count_m2[IDX_W-1:0];
            state_in  = S_MERGE_V;
         end

         S_MERGE_V, S_MERGE_H: begin
            if ((state_ff == S_MERGE_V) ? (same_cols && span_res.touch)
                                        : (same_rows && span_res.touch)) begin
               // fold the top into the entry below and pop
               mem_we    = 1'b1;
               mem_waddr = count_m2[IDX_W-1:0];
               mem_wdata = merged;
               top_in    = merged;
               count_in  = count_m1;
               state_in  = (count_m1 >= CNT_TWO) ? S_MERGE_RD : S_IDLE;
            end else begin
               state_in  = (state_ff == S_MERGE_V) ? S_MERGE_H : S_IDLE;
            end
         end

         S_DRAIN_RD: begin
            mem_re    = 1'b1;
            mem_raddr = drain_idx_ff;
            state_in  = S_DRAIN_OUT;
         end

         S_DRAIN_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_rect_in  = rd_data_ff;
               rsp_whole_in = 1'b0;
               rsp_last_in  = drain_last;
               if (drain_last) begin
                  count_in = '0;
                  state_in = S_IDLE;
               end else begin
                  drain_idx_in = drain_idx_ff + IDX_W'(1);
                  state_in     = S_DRAIN_RD;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      drain_idx_ff <= drain_idx_in;
      op_ff        <= op_in;
      item_ff      <= item_in;
      top_ff       <= top_in;
      rsp_rect_ff  <= rsp_rect_in;
      rsp_whole_ff <= rsp_whole_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // Stack RAM: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_data_ff <= stack_mem[mem_raddr];
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = RSP_DATA_W'(rsp_rect_ff);
   assign rsp_tuser[0] = rsp_whole_ff;
   assign rsp_tlast    = rsp_last_ff;

   // Checks.
   `DRC_ASSERT(a_count_bound, count_ff <= CNT_FULL)
   `DRC_ASSERT(a_busy_after_accept, req_xfer |=> !req_tready)
   `DRC_ASSERT(a_merge_needs_two, in_merge |-> (count_ff >= CNT_TWO))
   `DRC_ASSERT(a_drain_in_range, (state_ff == S_DRAIN_OUT) |-> (CNT_W'(drain_idx_ff) < count_ff))
   `DRC_NEVER(a_whole_clean, rsp_valid_ff && rsp_whole_ff && (rsp_rect_ff != '0 || !rsp_last_ff))

endmodule
